// ----- src/er3d_pkg.sv -----
// Euler rotation package: widths, fixed-point constants and the register index codes.
// No dependencies.
package er3d_pkg;
  localparam int CoordWidth = 32;
  localparam int AngleWidth = 20;
  localparam int AngBits = 19;
  localparam int Cfrac = AngleWidth - 2;
  localparam int CoefWidth = AngleWidth;
  localparam int ProdWidth = CoordWidth + CoefWidth;
  localparam int AccWidth = ProdWidth + 2;
  localparam int CfgIdxWidth = 2;

  localparam logic signed [AngBits+1:0] PiQ = 21'sd205887;
  localparam logic signed [AngBits+1:0] TwoPiQ = 21'sd411775;
  localparam logic [AngBits-1:0] HalfPiQ = 19'd102944;

  typedef logic signed [CoefWidth-1:0] coef_t;
  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegAngleX = 2'd0,
    RegAngleY = 2'd1,
    RegAngleZ = 2'd2,
    RegNone   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic  valid;
    coef_t c0;
    coef_t c1;
    coef_t c2;
  } row_t;

  typedef struct packed {
    logic signed [CoefWidth-1:0] sn;
    logic signed [CoefWidth-1:0] cs;
  } sc_t;
endpackage

// ----- src/er3d_sincos.sv -----
// Sequential sine/cosine unit: fold, Taylor series one term per Mul and Div state pair, round.
// Depends on er3d_pkg.
module er3d_sincos (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [er3d_pkg::AngBits-1:0] angle_i,
  output logic                        done_o,
  output er3d_pkg::sc_t               sc_o
);
  import er3d_pkg::*;

  typedef enum logic [2:0] {Idle, Prep, Mul, Div, Fin} st_e;

  // floor(n / d) for n < 2^32 as (n * ceil(2^(32+l) / d)) >> (32 + l), 2^(l-1) < d <= 2^l
  function automatic logic [32:0] recip(input int d, input int l);
    return 33'(((64'd1 << (32 + l)) + 64'(d) - 64'd1) / 64'(d));
  endfunction

  localparam int SLog [8] = '{0, 3, 5, 6, 7, 7, 8, 8};
  localparam int CLog [8] = '{0, 1, 4, 5, 6, 7, 8, 8};
  localparam logic [32:0] SMul [8] = '{recip(1, 0), recip(6, 3), recip(20, 5), recip(42, 6),
                                       recip(72, 7), recip(110, 7), recip(156, 8),
                                       recip(210, 8)};
  localparam logic [32:0] CMul [8] = '{recip(1, 0), recip(2, 1), recip(12, 4), recip(30, 5),
                                       recip(56, 6), recip(90, 7), recip(132, 8),
                                       recip(182, 8)};

  st_e                st_q;
  logic [2:0]         k_q;
  logic               sneg_q, cneg_q;
  logic [31:0]        x_q, x2_q;
  logic [31:0]        st_term_q, ct_term_q;
  logic [31:0]        sd_q, cd_q;
  logic signed [33:0] ssum_q, csum_q;
  logic signed [AngBits+1:0] a_w, a_f;
  logic [AngBits-1:0] t_w, t_f;
  logic [63:0]        xx, sp, cp;
  logic [64:0]        sq, cq;
  logic [31:0]        sdiv, cdiv;
  logic [CoefWidth-1:0] sr, cr;

  function automatic logic [CoefWidth-1:0] to_coef(input logic signed [33:0] s);
    logic [31:0] u;
    logic [32:0] r;
    begin
      if (s < 0) u = '0;
      else if (s > 34'sd1073741824) u = 32'd1073741824;
      else u = s[31:0];
      r = {1'b0, u} + 33'(1 << (30 - Cfrac - 1));
      to_coef = CoefWidth'(r >> (30 - Cfrac));
    end
  endfunction

  always_comb begin
    a_w = AngBits'(angle_i) == '0 ? '0 : {{2{angle_i[AngBits-1]}}, angle_i};
    if (a_w > PiQ) a_w = a_w - TwoPiQ;
    if (a_w < -PiQ) a_w = a_w + TwoPiQ;
    a_f = a_w < 0 ? -a_w : a_w;
    t_w = a_f[AngBits-1:0];
    t_f = t_w > HalfPiQ ? AngBits'(PiQ[AngBits-1:0] - t_w) : t_w;
    xx  = 64'({t_f, 14'd0}) * 64'({t_f, 14'd0});
    sp  = 64'(st_term_q) * 64'(x2_q);
    cp  = 64'(ct_term_q) * 64'(x2_q);
    sq  = 65'(sd_q) * 65'(SMul[k_q]);
    cq  = 65'(cd_q) * 65'(CMul[k_q]);
    sdiv = 32'(sq >> (32 + SLog[k_q]));
    cdiv = 32'(cq >> (32 + CLog[k_q]));
    sr  = to_coef(ssum_q);
    cr  = to_coef(csum_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= Idle;
      done_o <= 1'b0;
      k_q    <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (st_q)
        Idle: begin
          if (start_i) begin
            sneg_q <= a_w < 0;
            cneg_q <= t_w > HalfPiQ;
            x_q    <= 32'({t_f, 14'd0});
            x2_q   <= 32'(xx >> 30);
            st_q   <= Prep;
          end
        end
        Prep: begin
          st_term_q <= x_q;
          ct_term_q <= 32'd1073741824;
          ssum_q    <= 34'(x_q);
          csum_q    <= 34'sd1073741824;
          k_q       <= 3'd1;
          st_q      <= Mul;
        end
        Mul: begin
          sd_q <= 32'(sp >> 30);
          cd_q <= 32'(cp >> 30);
          st_q <= Div;
        end
        Div: begin
          st_term_q <= sdiv;
          ct_term_q <= cdiv;
          ssum_q <= k_q[0] ? ssum_q - 34'(sdiv) : ssum_q + 34'(sdiv);
          csum_q <= k_q[0] ? csum_q - 34'(cdiv) : csum_q + 34'(cdiv);
          k_q    <= k_q + 3'd1;
          st_q   <= (k_q == 3'd7) ? Fin : Mul;
        end
        Fin: begin
          sc_o.sn <= sneg_q ? -$signed(sr) : $signed(sr);
          sc_o.cs <= cneg_q ? -$signed(cr) : $signed(cr);
          done_o  <= 1'b1;
          st_q    <= Idle;
        end
        default: st_q <= Idle;
      endcase
    end
  end
endmodule

// ----- src/er3d_matrix.sv -----
// Coefficient builder: three sin/cos runs then one rounded product per cycle.
// Depends on er3d_pkg and er3d_sincos.
module er3d_matrix (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [er3d_pkg::AngBits-1:0] ax_i,
  input  logic [er3d_pkg::AngBits-1:0] ay_i,
  input  logic [er3d_pkg::AngBits-1:0] az_i,
  output logic                         busy_o,
  output er3d_pkg::coef_t              m_o [9]
);
  import er3d_pkg::*;

  localparam coef_t One = coef_t'(1 << Cfrac);

  typedef enum logic [2:0] {Idle, RunX, RunY, RunZ, Mul} st_e;

  st_e   st_q;
  logic  sc_start;
  logic  sc_done;
  logic  pend_q;
  logic  again_q;
  sc_t   sc;
  logic [AngBits-1:0] sel_ang;
  coef_t sx_q, cx_q, sy_q, cy_q, sz_q, cz_q, czsy_q, szsy_q;
  coef_t t_q [13];
  logic [3:0] step_q;
  coef_t ma, mb;
  coef_t rm;
  logic [2*CoefWidth-1:0] up;
  logic [CoefWidth-1:0] ua, ub;

  always_comb begin
    unique case (st_q)
      RunY:    sel_ang = ay_i;
      RunZ:    sel_ang = az_i;
      default: sel_ang = ax_i;
    endcase
    unique case (step_q)
      4'd0:  begin ma = cz_q;   mb = sy_q; end
      4'd1:  begin ma = sz_q;   mb = sy_q; end
      4'd2:  begin ma = cz_q;   mb = cy_q; end
      4'd3:  begin ma = sz_q;   mb = cy_q; end
      4'd4:  begin ma = czsy_q; mb = sx_q; end
      4'd5:  begin ma = sz_q;   mb = cx_q; end
      4'd6:  begin ma = szsy_q; mb = sx_q; end
      4'd7:  begin ma = cz_q;   mb = cx_q; end
      4'd8:  begin ma = cy_q;   mb = sx_q; end
      4'd9:  begin ma = czsy_q; mb = cx_q; end
      4'd10: begin ma = sz_q;   mb = sx_q; end
      4'd11: begin ma = szsy_q; mb = cx_q; end
      4'd12: begin ma = cz_q;   mb = sx_q; end
      default: begin ma = cy_q; mb = cx_q; end
    endcase
    ua = ma[CoefWidth-1] ? -ma : ma;
    ub = mb[CoefWidth-1] ? -mb : mb;
    up = (2*CoefWidth)'(ua) * (2*CoefWidth)'(ub) + (2*CoefWidth)'(1 << (Cfrac - 1));
    rm = coef_t'(up >> Cfrac);
    if (ma[CoefWidth-1] != mb[CoefWidth-1]) rm = -rm;
  end

  assign sc_start = (st_q == RunX || st_q == RunY || st_q == RunZ) && !pend_q;
  assign busy_o   = (st_q != Idle);

  er3d_sincos u_sc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sc_start),
    .angle_i (sel_ang),
    .done_o  (sc_done),
    .sc_o    (sc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= Idle;
      pend_q  <= 1'b0;
      again_q <= 1'b0;
      step_q  <= '0;
      for (int i = 0; i < 9; i++) m_o[i] <= (i == 0 || i == 4 || i == 8) ? One : '0;
    end else begin
      if (sc_start) pend_q <= 1'b1;
      if (start_i && st_q != Idle) again_q <= 1'b1;
      unique case (st_q)
        Idle: if (start_i) st_q <= RunX;
        RunX: if (sc_done) begin
          sx_q <= sc.sn; cx_q <= sc.cs; pend_q <= 1'b0; st_q <= RunY;
        end
        RunY: if (sc_done) begin
          sy_q <= sc.sn; cy_q <= sc.cs; pend_q <= 1'b0; st_q <= RunZ;
        end
        RunZ: if (sc_done) begin
          sz_q <= sc.sn; cz_q <= sc.cs; pend_q <= 1'b0; step_q <= '0; st_q <= Mul;
        end
        Mul: begin
          if (step_q == 4'd0) czsy_q <= rm;
          if (step_q == 4'd1) szsy_q <= rm;
          if (step_q != 4'd13) t_q[step_q] <= rm;
          step_q <= step_q + 4'd1;
          if (step_q == 4'd13) begin
            m_o[0]  <= t_q[2];
            m_o[1]  <= t_q[3];
            m_o[2]  <= -sy_q;
            m_o[3]  <= t_q[4] - t_q[5];
            m_o[4]  <= t_q[6] + t_q[7];
            m_o[5]  <= t_q[8];
            m_o[6]  <= t_q[9] + t_q[10];
            m_o[7]  <= t_q[11] - t_q[12];
            m_o[8]  <= rm;
            again_q <= 1'b0;
            st_q    <= (start_i || again_q) ? RunX : Idle;
          end
        end
        default: st_q <= Idle;
      endcase
    end
  end
endmodule

// ----- src/er3d_lane.sv -----
// One output lane: three coefficient-coordinate products, sum, round, saturate.
// Depends on er3d_pkg.
module er3d_lane (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  er3d_pkg::coef_t       c_i [3],
  input  er3d_pkg::coord_t      v_i [3],
  output er3d_pkg::coord_t      r_o
);
  import er3d_pkg::*;

  logic signed [ProdWidth-1:0] p_q [3];
  logic signed [AccWidth-1:0]  s_q;
  logic signed [AccWidth-1:0]  mag;
  logic signed [AccWidth-1:0]  q;
  logic                        neg_q;

  localparam logic signed [AccWidth-1:0] Lim = AccWidth'((64'd1 << (CoordWidth - 1)) - 1);

  always_comb begin
    mag = neg_q ? -s_q : s_q;
    q   = (mag + AccWidth'(1 << (Cfrac - 1))) >>> Cfrac;
    if (!neg_q) r_o = q > Lim ? coord_t'(Lim) : coord_t'(q);
    else r_o = q > Lim + 1 ? coord_t'(-Lim - 1) : coord_t'(-q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) p_q[j] <= ProdWidth'(c_i[j]) * ProdWidth'(v_i[j]);
    end
  end

  logic signed [AccWidth-1:0] sum;
  assign sum = AccWidth'(p_q[0]) + AccWidth'(p_q[1]) + AccWidth'(p_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q   <= sum;
      neg_q <= sum < 0;
    end
  end
endmodule

// ----- src/euler_rotation_3d_unit.sv -----
// Euler-angle 3D rotation unit top level: config registers, coefficient builder,
// three lanes and the merged output stage. Depends on er3d_pkg, er3d_matrix, er3d_lane.
// Accepted requests pass the product, sum and output registers; throughput one request per
// cycle, stalls propagate back through the whole pipe. A register write rebuilds the matrix,
// during which requests are stalled. Reset: angles zero, matrix identity.
module euler_rotation_3d_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [er3d_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [er3d_pkg::AngBits-1:0] cfg_data_i,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  er3d_pkg::coord_t             x_in_i,
  input  er3d_pkg::coord_t             y_in_i,
  input  er3d_pkg::coord_t             z_in_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output er3d_pkg::coord_t             x_out_o,
  output er3d_pkg::coord_t             y_out_o,
  output er3d_pkg::coord_t             z_out_o
);
  import er3d_pkg::*;

  logic [AngBits-1:0] ax_q, ay_q, az_q;
  logic   wr;
  logic   busy;
  coef_t  m [9];
  coord_t v [3];
  coef_t  c0 [3], c1 [3], c2 [3];
  coord_t r [3];
  logic [2:0] vld_q;
  logic en;

  assign wr = cfg_we_i && (reg_idx_e'(cfg_idx_i) != RegNone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0; ay_q <= '0; az_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegAngleX: ax_q <= cfg_data_i;
        RegAngleY: ay_q <= cfg_data_i;
        RegAngleZ: az_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  er3d_matrix u_mat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wr),
    .ax_i    (ax_q),
    .ay_i    (ay_q),
    .az_i    (az_q),
    .busy_o  (busy),
    .m_o     (m)
  );

  assign v  = '{x_in_i, y_in_i, z_in_i};
  assign c0 = '{m[0], m[1], m[2]};
  assign c1 = '{m[3], m[4], m[5]};
  assign c2 = '{m[6], m[7], m[8]};

  assign en      = !(valid_o && stall_i);
  assign stall_o = !en || busy;

  er3d_lane u_l0 (.clk_i(clk_i), .en_i(en), .c_i(c0), .v_i(v), .r_o(r[0]));
  er3d_lane u_l1 (.clk_i(clk_i), .en_i(en), .c_i(c1), .v_i(v), .r_o(r[1]));
  er3d_lane u_l2 (.clk_i(clk_i), .en_i(en), .c_i(c2), .v_i(v), .r_o(r[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
    end else if (en) begin
      vld_q <= {vld_q[1:0], valid_i && !busy};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_out_o <= r[0];
      y_out_o <= r[1];
      z_out_o <= r[2];
    end
  end

  assign valid_o = vld_q[2];
endmodule
